@@ hw/rtl/prml_pkg.sv @@
package prml_pkg;

	localparam logic [7:0] OP_JUMP = 8'h4C;

	// Loader phases.
	localparam logic [2:0] PH_HEAD0      = 3'd0;
	localparam logic [2:0] PH_HEAD1      = 3'd1;
	localparam logic [2:0] PH_EXPORTS    = 3'd2;
	localparam logic [2:0] PH_IMPORTS    = 3'd3;
	localparam logic [2:0] PH_CODE_FIRST = 3'd4;
	localparam logic [2:0] PH_CODE       = 3'd5;
	localparam logic [2:0] PH_ABSORB     = 3'd6;

	localparam logic [1:0] KIND_TABLE = 2'd0;
	localparam logic [1:0] KIND_CODE  = 2'd1;
	localparam logic [1:0] KIND_RELOC = 2'd2;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_NOJUMP  = 2'd1;
	localparam logic [1:0] ST_FOREIGN = 2'd2;

	localparam logic CFG_LOAD_BASE     = 1'b0;
	localparam logic CFG_MODULE_LENGTH = 1'b1;

	localparam int MAX_RESULTS = 3;

	typedef struct packed {
		logic [7:0] out_byte;
		logic [1:0] byte_kind;
		logic [1:0] status;
		logic       last;
	} result_t;

	typedef struct packed {
		logic [1:0]                    cnt;
		result_t [MAX_RESULTS-1:0]     res;
	} bundle_t;

	typedef struct packed {
		logic [15:0] load_base;
		logic [15:0] module_length;
	} cfg_t;

	function automatic result_t mk_result(logic [7:0] b, logic [1:0] kind, logic [1:0] st);
		result_t r;
		r.out_byte  = b;
		r.byte_kind = kind;
		r.status    = st;
		r.last      = 1'b0;
		return r;
	endfunction

endpackage

@@ hw/rtl/prml_byte_if.sv @@
interface prml_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;

	modport source (output valid, output in_byte, input ready);
	modport sink (input valid, input in_byte, output ready);
endinterface

@@ hw/rtl/prml_result_if.sv @@
interface prml_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic [1:0] byte_kind;
	logic [1:0] status;
	logic       last;

	modport source (output valid, output out_byte, output byte_kind, output status,
		output last, input ready);
	modport sink (input valid, input out_byte, input byte_kind, input status,
		input last, output ready);
endinterface

@@ hw/rtl/prml_step.sv @@
module prml_step (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [7:0]        in_byte,
	input  prml_pkg::cfg_t    cfg,
	output prml_pkg::bundle_t bundle
);
	import prml_pkg::*;

	logic [2:0]  phase_q, phase_n;
	logic [15:0] pos_q, pos_n;
	logic [7:0]  page_q, page_n;
	logic [7:0]  entry0_q, entry0_n, entry1_q, entry1_n;
	logic [1:0]  idx_q, idx_n;
	logic [7:0]  held_q, held_n;
	logic        hh_q, hh_n;

	logic [8:0]  pages;
	logic [8:0]  page_off;
	logic        in_span;
	logic [7:0]  reloc_lo;
	logic [15:0] addr;
	logic [1:0]  n;

	// A length of zero stands for a full 64 KiB module.
	assign pages    = (cfg.module_length == 16'd0) ? 9'd256 :
		9'(({1'b0, cfg.module_length} + 17'd255) >> 8);
	assign page_off = 9'({1'b0, in_byte} - {1'b0, page_q});
	assign in_span  = (in_byte >= page_q) && (page_off < pages);

	// Export entries and code pairs both take the high byte from the current item.
	assign reloc_lo = (phase_q == PH_EXPORTS) ? entry1_q : held_q;
	assign addr     = cfg.load_base + {in_byte - page_q, reloc_lo};

	always_comb begin
		phase_n  = phase_q;
		pos_n    = pos_q + 16'd1;
		page_n   = page_q;
		entry0_n = entry0_q;
		entry1_n = entry1_q;
		idx_n    = idx_q;
		held_n   = held_q;
		hh_n     = hh_q;
		n        = 2'd0;
		bundle.res = '0;

		unique case (phase_q) inside
			PH_HEAD0: begin
				if (in_byte != 8'd0) begin
					bundle.res[n] = mk_result(8'd0, KIND_TABLE, ST_FOREIGN);
					n = n + 2'd1;
					phase_n = PH_ABSORB;
				end else begin
					phase_n = PH_HEAD1;
				end
			end
			PH_HEAD1: begin
				page_n  = in_byte;
				idx_n   = 2'd0;
				phase_n = PH_EXPORTS;
			end
			PH_EXPORTS, PH_IMPORTS: begin
				if (idx_q == 2'd0) begin
					entry0_n = in_byte;
					idx_n    = 2'd1;
				end else if (idx_q == 2'd1) begin
					entry1_n = in_byte;
					idx_n    = 2'd2;
				end else begin
					idx_n = 2'd0;
					if (entry0_q == 8'd0 && entry1_q == 8'd0 && in_byte == 8'd0) begin
						bundle.res[0] = mk_result(8'd0, KIND_TABLE, ST_OK);
						bundle.res[1] = mk_result(8'd0, KIND_TABLE, ST_OK);
						bundle.res[2] = mk_result(8'd0, KIND_TABLE, ST_OK);
						n = 2'd3;
						phase_n = (phase_q == PH_EXPORTS) ? PH_IMPORTS : PH_CODE_FIRST;
					end else if (entry0_q != OP_JUMP) begin
						bundle.res[0] = mk_result(8'd0, KIND_TABLE, ST_NOJUMP);
						n = 2'd1;
						phase_n = PH_ABSORB;
					end else if (phase_q == PH_EXPORTS) begin
						bundle.res[0] = mk_result(entry0_q, KIND_TABLE, ST_OK);
						bundle.res[1] = mk_result(addr[7:0], KIND_RELOC, ST_OK);
						bundle.res[2] = mk_result(addr[15:8], KIND_RELOC, ST_OK);
						n = 2'd3;
					end else begin
						bundle.res[0] = mk_result(entry0_q, KIND_TABLE, ST_OK);
						bundle.res[1] = mk_result(entry1_q, KIND_TABLE, ST_OK);
						bundle.res[2] = mk_result(in_byte, KIND_TABLE, ST_OK);
						n = 2'd3;
					end
				end
			end
			PH_CODE_FIRST: begin
				held_n  = in_byte;
				hh_n    = 1'b0;
				phase_n = PH_CODE;
			end
			PH_CODE: begin
				// The held byte's fate is settled by the byte that follows it.
				if (hh_q) begin
					bundle.res[0] = mk_result(held_q, KIND_RELOC, ST_OK);
					held_n = in_byte;
					hh_n   = 1'b0;
				end else if (in_span) begin
					bundle.res[0] = mk_result(addr[7:0], KIND_RELOC, ST_OK);
					held_n = addr[15:8];
					hh_n   = 1'b1;
				end else begin
					bundle.res[0] = mk_result(held_q, KIND_CODE, ST_OK);
					held_n = in_byte;
				end
				n = 2'd1;
			end
			default: begin
			end
		endcase

		if (pos_n == cfg.module_length) begin
			if (phase_n == PH_CODE) begin
				bundle.res[n] = mk_result(held_n, hh_n ? KIND_RELOC : KIND_CODE, ST_OK);
				n = n + 2'd1;
			end
			phase_n = PH_HEAD0;
			pos_n   = 16'd0;
			idx_n   = 2'd0;
			held_n  = 8'd0;
			hh_n    = 1'b0;
		end

		if (n != 2'd0) begin
			bundle.res[n - 2'd1].last = 1'b1;
		end
		bundle.cnt = n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEAD0;
			pos_q   <= '0;
			page_q  <= '0;
			idx_q   <= '0;
			held_q  <= '0;
			hh_q    <= 1'b0;
		end else if (accept) begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			page_q  <= page_n;
			idx_q   <= idx_n;
			held_q  <= held_n;
			hh_q    <= hh_n;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			entry0_q <= entry0_n;
			entry1_q <= entry1_n;
		end
	end

	a_absorb_silent: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_ABSORB |-> bundle.cnt == 2'd0)
		else $error("item in absorb phase produced results");

	a_high_half_in_code: assert property (@(posedge clk) disable iff (!arst_n)
		hh_q |-> phase_q == PH_CODE)
		else $error("held high half outside code phase");

	a_foreign_header: assert property (@(posedge clk) disable iff (!arst_n)
		accept && phase_q == PH_HEAD0 && in_byte != 8'd0
		|=> phase_q == PH_ABSORB || phase_q == PH_HEAD0)
		else $error("foreign header did not skip the module");

endmodule

@@ hw/rtl/prml_out_buf.sv @@
module prml_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  prml_pkg::bundle_t bundle,
	input  logic              accept,
	output logic              can_accept,
	prml_result_if.source     out_ch
);
	import prml_pkg::*;

	result_t [MAX_RESULTS-1:0] res_q;
	logic [1:0]                cnt_q;
	logic [1:0]                rd_q;
	logic                      empty;
	logic                      pop;
	result_t                   cur;

	assign empty = (rd_q == cnt_q);
	assign pop   = out_ch.valid && out_ch.ready;
	assign cur   = res_q[rd_q];

	// A new item may enter while the last buffered result leaves.
	assign can_accept = empty || (pop && (rd_q + 2'd1 == cnt_q));

	assign out_ch.valid     = !empty;
	assign out_ch.out_byte  = cur.out_byte;
	assign out_ch.byte_kind = cur.byte_kind;
	assign out_ch.status    = cur.status;
	assign out_ch.last      = cur.last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_q  <= '0;
		end else if (accept) begin
			cnt_q <= bundle.cnt;
			rd_q  <= '0;
		end else if (pop) begin
			rd_q <= rd_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			res_q <= bundle.res;
		end
	end

	a_rd_bound: assert property (@(posedge clk) disable iff (!arst_n)
		rd_q <= cnt_q)
		else $error("read pointer passed result count");

	a_last_at_end: assert property (@(posedge clk) disable iff (!arst_n)
		out_ch.valid |-> (out_ch.last == (rd_q + 2'd1 == cnt_q)))
		else $error("last flag not on final result of item");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		accept |-> empty || pop)
		else $error("item accepted over pending results");

endmodule

@@ hw/rtl/page_relocating_module_loader.sv @@
// Streams one library module in, one byte per item, and streams it out relocated
// to load_base. Each accepted byte is decoded against the loader state in the same
// cycle and its zero to three results land in a result buffer, seen on out_ch from
// the next cycle. Code bytes are delayed by one item, since whether a byte is the low
// half of an address depends on the byte after it; the held byte is flushed when the
// module length is reached. A byte is taken every cycle as long as it causes at most
// one result and the output side is ready; a completed table entry puts three results
// in the buffer, so the next byte waits until the buffer is on its last result.
// Write load_base and module_length only while the block is idle.
module page_relocating_module_loader (
	input  logic          clk,
	input  logic          arst_n,
	prml_byte_if.sink     in_ch,
	prml_result_if.source out_ch,
	input  logic          cfg_we,
	input  logic          cfg_index,
	input  logic [15:0]   cfg_data
);
	import prml_pkg::*;

	cfg_t    cfg_q;
	bundle_t bundle;
	logic    accept;
	logic    can_accept;

	assign in_ch.ready = can_accept;
	assign accept      = in_ch.valid && can_accept;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			if (cfg_index == CFG_LOAD_BASE) begin
				cfg_q.load_base <= cfg_data;
			end else if (cfg_index == CFG_MODULE_LENGTH) begin
				cfg_q.module_length <= cfg_data;
			end
		end
	end

	prml_step u_step (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.in_byte (in_ch.in_byte),
		.cfg     (cfg_q),
		.bundle  (bundle)
	);

	prml_out_buf u_out_buf (
		.clk        (clk),
		.arst_n     (arst_n),
		.bundle     (bundle),
		.accept     (accept),
		.can_accept (can_accept),
		.out_ch     (out_ch)
	);

endmodule
